@@ rtl/core/tsf_pkg.sv @@
`default_nettype none

package tsf_pkg;

    // TCP flag bit positions in the flag byte
    localparam int unsigned FLAG_FIN_BIT = 0;
    localparam int unsigned FLAG_SYN_BIT = 1;
    localparam int unsigned FLAG_PSH_BIT = 3;
    localparam int unsigned FLAG_ACK_BIT = 4;

    // Flag bytes of sent segments
    localparam logic [7:0] SEND_FLAGS_ACK     = 8'h10;
    localparam logic [7:0] SEND_FLAGS_SYN_ACK = 8'h12;

    // IPv4 header length, bytes
    localparam logic [6:0] IP_HEADER_BYTES = 7'd20;

    // Configuration register indexes
    localparam logic CFG_INITIAL_SEND_SEQ  = 1'b0;
    localparam logic CFG_ADVERTISED_WINDOW = 1'b1;

    // Error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_BAD_CHECKSUM = 2'd1;
    localparam logic [1:0] ERR_SYN_IN_EST   = 2'd2;

    // Reported connection state codes
    localparam logic [3:0] CODE_CLOSED      = 4'd0;
    localparam logic [3:0] CODE_LISTEN      = 4'd1;
    localparam logic [3:0] CODE_SYN_RCVD    = 4'd2;
    localparam logic [3:0] CODE_ESTABLISHED = 4'd4;
    localparam logic [3:0] CODE_CLOSE_WAIT  = 4'd9;
    localparam logic [3:0] CODE_LAST_ACK    = 4'd10;

    typedef enum logic [5:0] {
        ST_CLOSED      = 6'b000001,
        ST_LISTEN      = 6'b000010,
        ST_SYN_RCVD    = 6'b000100,
        ST_ESTABLISHED = 6'b001000,
        ST_CLOSE_WAIT  = 6'b010000,
        ST_LAST_ACK    = 6'b100000
    } t_conn_state;

    typedef struct packed {
        logic        checksum_ok;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dst_port;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [7:0]  seg_flags;
        logic [3:0]  header_words;
        logic [15:0] ip_total_length;
    } t_seg;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_flags;
        logic [31:0] send_seq;
        logic [31:0] send_ack;
        logic [15:0] send_src_port;
        logic [15:0] send_dst_port;
        logic        deliver_valid;
        logic [15:0] deliver_length;
        logic [3:0]  conn_state;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_result;

    // Outcome of one segment: next connection context and up to two results
    typedef struct packed {
        t_conn_state next_state;
        logic [31:0] next_rcv;
        logic [31:0] next_snd;
        t_result     res_first;
        t_result     res_second;
        logic        two_results;
    } t_eval;

    function automatic logic [3:0] state_code(input t_conn_state st);
        logic [3:0] code;
        case (st)
            ST_CLOSED:      code = CODE_CLOSED;
            ST_LISTEN:      code = CODE_LISTEN;
            ST_SYN_RCVD:    code = CODE_SYN_RCVD;
            ST_ESTABLISHED: code = CODE_ESTABLISHED;
            ST_CLOSE_WAIT:  code = CODE_CLOSE_WAIT;
            ST_LAST_ACK:    code = CODE_LAST_ACK;
            default:        code = CODE_CLOSED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tsf_channels.sv @@
`default_nettype none

// Received segment header channel
interface tsf_seg_if;
    logic        valid;
    logic        ready;
    logic        checksum_ok;
    logic [15:0] seg_src_port;
    logic [15:0] seg_dst_port;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [7:0]  seg_flags;
    logic [3:0]  header_words;
    logic [15:0] ip_total_length;

    modport source (
        output valid, checksum_ok, seg_src_port, seg_dst_port, seg_seq, seg_ack,
               seg_flags, header_words, ip_total_length,
        input  ready
    );
    modport sink (
        input  valid, checksum_ok, seg_src_port, seg_dst_port, seg_seq, seg_ack,
               seg_flags, header_words, ip_total_length,
        output ready
    );
endinterface

// Result channel
interface tsf_res_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [7:0]  send_flags;
    logic [31:0] send_seq;
    logic [31:0] send_ack;
    logic [15:0] send_src_port;
    logic [15:0] send_dst_port;
    logic        deliver_valid;
    logic [15:0] deliver_length;
    logic [3:0]  conn_state;
    logic [1:0]  error_code;
    logic        last_of_run;

    modport source (
        output valid, send_valid, send_flags, send_seq, send_ack, send_src_port,
               send_dst_port, deliver_valid, deliver_length, conn_state,
               error_code, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_flags, send_seq, send_ack, send_src_port,
               send_dst_port, deliver_valid, deliver_length, conn_state,
               error_code, last_of_run,
        output ready
    );
endinterface

// Configuration write channel
interface tsf_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tsf_seg_eval.sv @@
`default_nettype none

module tsf_seg_eval
    import tsf_pkg::*;
(
    input  wire t_conn_state i_state,
    input  wire logic [31:0] i_rcv_next,
    input  wire logic [31:0] i_snd_next,
    input  wire logic [31:0] i_init_seq,
    input  wire t_seg        i_seg,
    output t_eval            o_eval
);

    logic        flag_fin;
    logic        flag_syn;
    logic        flag_psh;
    logic        flag_ack;
    logic [6:0]  need_bytes;
    logic [15:0] pay_len;
    logic [31:0] rcv_after_psh;
    logic [31:0] rcv_after_fin;
    logic [1:0]  err;
    logic [3:0]  code;
    t_result     send_tmpl;
    t_result     fin_res;

    assign flag_fin = i_seg.seg_flags[FLAG_FIN_BIT];
    assign flag_syn = i_seg.seg_flags[FLAG_SYN_BIT];
    assign flag_psh = i_seg.seg_flags[FLAG_PSH_BIT];
    assign flag_ack = i_seg.seg_flags[FLAG_ACK_BIT];

    // Payload length, saturated to zero for short segments
    assign need_bytes = IP_HEADER_BYTES + {1'b0, i_seg.header_words, 2'b00};
    assign pay_len    = (i_seg.ip_total_length > {9'd0, need_bytes})
                      ? (i_seg.ip_total_length - {9'd0, need_bytes}) : 16'd0;

    assign rcv_after_psh = flag_psh ? (i_rcv_next + {16'd0, pay_len}) : i_rcv_next;
    assign rcv_after_fin = rcv_after_psh + 32'd1;

    always_comb begin
        o_eval            = '0;
        o_eval.next_state = i_state;
        o_eval.next_rcv   = i_rcv_next;
        o_eval.next_snd   = i_snd_next;
        err               = ERR_NONE;

        // Common fields of an answering segment: ports swapped
        send_tmpl               = '0;
        send_tmpl.send_valid    = 1'b1;
        send_tmpl.send_src_port = i_seg.seg_dst_port;
        send_tmpl.send_dst_port = i_seg.seg_src_port;

        fin_res                = send_tmpl;
        fin_res.send_flags     = SEND_FLAGS_ACK;
        fin_res.send_seq       = i_seg.seg_ack;
        fin_res.send_ack       = rcv_after_fin;
        fin_res.deliver_valid  = 1'b1;
        fin_res.deliver_length = 16'd0;

        if (!i_seg.checksum_ok) begin
            err = ERR_BAD_CHECKSUM;
        end else begin
            case (i_state)
                ST_LISTEN: begin
                    if (flag_syn) begin
                        o_eval.next_state           = ST_SYN_RCVD;
                        o_eval.next_snd             = i_init_seq;
                        o_eval.next_rcv             = i_seg.seg_seq + 32'd1;
                        o_eval.res_first            = send_tmpl;
                        o_eval.res_first.send_flags = SEND_FLAGS_SYN_ACK;
                        o_eval.res_first.send_seq   = i_init_seq;
                        o_eval.res_first.send_ack   = i_seg.seg_seq + 32'd1;
                    end
                end
                ST_SYN_RCVD: begin
                    if (flag_ack) begin
                        o_eval.next_state = ST_ESTABLISHED;
                    end
                end
                ST_ESTABLISHED: begin
                    if (flag_syn) begin
                        err = ERR_SYN_IN_EST;
                    end else begin
                        if (flag_psh || flag_fin) begin
                            o_eval.next_snd = i_seg.seg_ack;
                        end
                        o_eval.next_rcv = flag_fin ? rcv_after_fin : rcv_after_psh;
                        if (flag_fin) begin
                            o_eval.next_state = ST_CLOSE_WAIT;
                        end
                        // PSH result leads; FIN result follows or stands alone
                        if (flag_psh) begin
                            o_eval.res_first                = send_tmpl;
                            o_eval.res_first.send_flags     = SEND_FLAGS_ACK;
                            o_eval.res_first.send_seq       = i_seg.seg_ack;
                            o_eval.res_first.send_ack       = rcv_after_psh;
                            o_eval.res_first.deliver_valid  = 1'b1;
                            o_eval.res_first.deliver_length = pay_len;
                            if (flag_fin) begin
                                o_eval.res_second  = fin_res;
                                o_eval.two_results = 1'b1;
                            end
                        end else if (flag_fin) begin
                            o_eval.res_first = fin_res;
                        end
                    end
                end
                ST_LAST_ACK: begin
                    if (flag_ack) begin
                        o_eval.next_state = ST_CLOSED;
                    end
                end
                default: begin
                    // closed and close_wait ignore every segment
                end
            endcase
        end

        // Status fields carry the state after the whole segment
        code                          = state_code(o_eval.next_state);
        o_eval.res_first.conn_state   = code;
        o_eval.res_first.error_code   = err;
        o_eval.res_first.last_of_run  = !o_eval.two_results;
        o_eval.res_second.conn_state  = code;
        o_eval.res_second.error_code  = err;
        o_eval.res_second.last_of_run = 1'b1;
    end

endmodule

`default_nettype wire

@@ rtl/core/tcp_server_connection_fsm_unit.sv @@
`default_nettype none

// Receive-side state machine of one passive-open TCP connection.
// i_seg carries one parsed segment header per beat; o_res carries result
// beats; i_cfg writes registers (index 0 initial send sequence, index 1
// advertised window, which no result field shows and which is not stored).
// A beat moves on any channel at a clock edge where valid and ready are high.
// A segment beat is captured in an input register, evaluated against the
// connection context once the result register is free or draining, and its
// results land in the result register, from which o_res offers them. One
// segment per cycle is taken while results drain every cycle and no segment
// has two results; a segment with both PSH and FIN yields two result beats,
// and the second waits in its own register until the first is taken.
// When o_res stalls, the held result and a pending second result wait, one
// more segment parks in the input register, then i_seg.ready drops.
// Synchronous active-low reset empties all stages, puts the connection in
// LISTEN with both sequence values zero and clears the initial send
// sequence. i_cfg.ready is always high; write only while the block is idle.
module tcp_server_connection_fsm_unit
    import tsf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tsf_seg_if.sink   i_seg,
    tsf_res_if.source o_res,
    tsf_cfg_if.sink   i_cfg
);

    logic        r_in_valid;
    t_seg        r_in;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_second_valid;
    t_result     r_second;
    t_conn_state r_state;
    logic [31:0] r_rcv_next;
    logic [31:0] r_snd_next;
    logic [31:0] r_init_seq;

    t_seg        seg_beat;
    t_eval       eval;
    logic        out_take;
    logic        eval_fire;
    logic        seg_take;

    assign seg_beat.checksum_ok     = i_seg.checksum_ok;
    assign seg_beat.seg_src_port    = i_seg.seg_src_port;
    assign seg_beat.seg_dst_port    = i_seg.seg_dst_port;
    assign seg_beat.seg_seq         = i_seg.seg_seq;
    assign seg_beat.seg_ack         = i_seg.seg_ack;
    assign seg_beat.seg_flags       = i_seg.seg_flags;
    assign seg_beat.header_words    = i_seg.header_words;
    assign seg_beat.ip_total_length = i_seg.ip_total_length;

    tsf_seg_eval u_eval (
        .i_state    (r_state),
        .i_rcv_next (r_rcv_next),
        .i_snd_next (r_snd_next),
        .i_init_seq (r_init_seq),
        .i_seg      (r_in),
        .o_eval     (eval)
    );

    // Handshakes: evaluate when the result register is free or draining and no second result is pending
    assign out_take  = r_out_valid && o_res.ready;
    assign eval_fire = r_in_valid && !r_second_valid && (!r_out_valid || o_res.ready);
    assign seg_take  = i_seg.valid && i_seg.ready;

    assign i_seg.ready = !r_in_valid || eval_fire;
    assign i_cfg.ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (seg_take) begin
            r_in_valid <= 1'b1;
        end else if (eval_fire) begin
            r_in_valid <= 1'b0;
        end
        if (seg_take) begin
            r_in <= seg_beat;
        end
    end

    // Connection context: advance once per evaluated segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LISTEN;
            r_rcv_next <= 32'd0;
            r_snd_next <= 32'd0;
        end else if (eval_fire) begin
            r_state    <= eval.next_state;
            r_rcv_next <= eval.next_rcv;
            r_snd_next <= eval.next_snd;
        end
    end

    // Result register and pending second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_second_valid <= 1'b0;
        end else begin
            if (eval_fire) begin
                r_out_valid    <= 1'b1;
                r_second_valid <= eval.two_results;
            end else if (out_take) begin
                r_out_valid    <= r_second_valid;
                r_second_valid <= 1'b0;
            end
        end
        if (eval_fire) begin
            r_out    <= eval.res_first;
            r_second <= eval.res_second;
        end else if (out_take && r_second_valid) begin
            r_out <= r_second;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_seq <= 32'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_INITIAL_SEND_SEQ:  r_init_seq <= i_cfg.data;
                CFG_ADVERTISED_WINDOW: r_init_seq <= r_init_seq;
                default:               r_init_seq <= r_init_seq;
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.send_valid     = r_out.send_valid;
    assign o_res.send_flags     = r_out.send_flags;
    assign o_res.send_seq       = r_out.send_seq;
    assign o_res.send_ack       = r_out.send_ack;
    assign o_res.send_src_port  = r_out.send_src_port;
    assign o_res.send_dst_port  = r_out.send_dst_port;
    assign o_res.deliver_valid  = r_out.deliver_valid;
    assign o_res.deliver_length = r_out.deliver_length;
    assign o_res.conn_state     = r_out.conn_state;
    assign o_res.error_code     = r_out.error_code;
    assign o_res.last_of_run    = r_out.last_of_run;

endmodule

`default_nettype wire

@@ bench/tcp_server_connection_fsm_unit_tb.sv @@
module tcp_server_connection_fsm_unit_tb;
    import tsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] FL_FIN = 8'h01 << FLAG_FIN_BIT;
    localparam logic [7:0] FL_SYN = 8'h01 << FLAG_SYN_BIT;
    localparam logic [7:0] FL_PSH = 8'h01 << FLAG_PSH_BIT;
    localparam logic [7:0] FL_ACK = 8'h01 << FLAG_ACK_BIT;

    localparam int DIRECTED_ROWS = 21;
    localparam int CLOSING_ROW   = 18;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 260;
    localparam int IDLE_PERCENT  = 29;

    typedef struct packed {
        t_seg    seg;
        logic    typed;
        t_result want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsf_seg_if seg_bus ();
    tsf_res_if res_bus ();
    tsf_cfg_if cfg_bus ();

    tcp_server_connection_fsm_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Connection context mirrored from the segment stream
    logic [3:0]  conn_code;
    logic [31:0] rcv_next;
    logic [31:0] snd_next;
    logic [31:0] iss_reg;
    logic [15:0] window_reg;

    t_result   expected_q[$];
    t_stim_row directed_rows[DIRECTED_ROWS];
    bit        idle_on;
    int        mismatches;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_seg make_seg(logic ok, logic [15:0] src, logic [15:0] dst,
                                      logic [31:0] seq, logic [31:0] ack,
                                      logic [7:0] flags, logic [3:0] hw,
                                      logic [15:0] len);
        t_seg s;
        s.checksum_ok     = ok;
        s.seg_src_port    = src;
        s.seg_dst_port    = dst;
        s.seg_seq         = seq;
        s.seg_ack         = ack;
        s.seg_flags       = flags;
        s.header_words    = hw;
        s.ip_total_length = len;
        return s;
    endfunction

    function automatic t_stim_row stim(t_seg s, logic typed, t_result want);
        t_stim_row r;
        r.seg   = s;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_result status_beat(logic [3:0] st, logic [1:0] err);
        t_result r;
        r = '0;
        r.conn_state  = st;
        r.error_code  = err;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    // Outgoing segment fields, ports swapped from the received segment
    function automatic t_result segment_beat(logic [7:0] flags, logic [31:0] seq,
                                             logic [31:0] ack, t_seg s);
        t_result r;
        r = '0;
        r.send_valid    = 1'b1;
        r.send_flags    = flags;
        r.send_seq      = seq;
        r.send_ack      = ack;
        r.send_src_port = s.seg_dst_port;
        r.send_dst_port = s.seg_src_port;
        return r;
    endfunction

    // Apply one segment to the mirrored context and form its result beats
    task automatic advance_connection(input t_seg s, output t_result r_a,
                                      output t_result r_b, output int count);
        logic [1:0]  err;
        logic [16:0] need;
        logic [15:0] pay;
        t_result     fin_beat;
        r_a   = '0;
        r_b   = '0;
        err   = ERR_NONE;
        count = 0;
        if (!s.checksum_ok) begin
            err = ERR_BAD_CHECKSUM;
        end else begin
            case (conn_code)
                CODE_LISTEN: begin
                    if (s.seg_flags[FLAG_SYN_BIT]) begin
                        snd_next  = iss_reg;
                        rcv_next  = s.seg_seq + 32'd1;
                        r_a       = segment_beat(SEND_FLAGS_SYN_ACK, snd_next, rcv_next, s);
                        conn_code = CODE_SYN_RCVD;
                        count     = 1;
                    end
                end
                CODE_SYN_RCVD: begin
                    if (s.seg_flags[FLAG_ACK_BIT]) conn_code = CODE_ESTABLISHED;
                end
                CODE_ESTABLISHED: begin
                    if (s.seg_flags[FLAG_SYN_BIT]) begin
                        err = ERR_SYN_IN_EST;
                    end else begin
                        if (s.seg_flags[FLAG_PSH_BIT]) begin
                            need = 17'(IP_HEADER_BYTES) + 17'({s.header_words, 2'b00});
                            pay  = (17'(s.ip_total_length) > need) ?
                                   16'(17'(s.ip_total_length) - need) : 16'd0;
                            rcv_next = rcv_next + 32'(pay);
                            snd_next = s.seg_ack;
                            r_a = segment_beat(SEND_FLAGS_ACK, snd_next, rcv_next, s);
                            r_a.deliver_valid  = 1'b1;
                            r_a.deliver_length = pay;
                            count = 1;
                        end
                        if (s.seg_flags[FLAG_FIN_BIT]) begin
                            conn_code = CODE_CLOSE_WAIT;
                            rcv_next  = rcv_next + 32'd1;
                            snd_next  = s.seg_ack;
                            fin_beat  = segment_beat(SEND_FLAGS_ACK, snd_next, rcv_next, s);
                            fin_beat.deliver_valid = 1'b1;
                            if (count == 0) r_a = fin_beat;
                            else r_b = fin_beat;
                            count++;
                        end
                    end
                end
                CODE_LAST_ACK: begin
                    if (s.seg_flags[FLAG_ACK_BIT]) conn_code = CODE_CLOSED;
                end
                default: ;
            endcase
        end
        if (count == 0) count = 1;
        r_a.conn_state  = conn_code;
        r_a.error_code  = err;
        r_a.last_of_run = (count == 1);
        r_b.conn_state  = conn_code;
        r_b.error_code  = err;
        r_b.last_of_run = 1'b1;
    endtask

    // Drive one segment beat, hold until accepted, then queue its results
    task automatic offer_segment(input t_stim_row row);
        t_result r_a;
        t_result r_b;
        int      count;
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            seg_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_bus.valid           <= 1'b1;
        seg_bus.checksum_ok     <= row.seg.checksum_ok;
        seg_bus.seg_src_port    <= row.seg.seg_src_port;
        seg_bus.seg_dst_port    <= row.seg.seg_dst_port;
        seg_bus.seg_seq         <= row.seg.seg_seq;
        seg_bus.seg_ack         <= row.seg.seg_ack;
        seg_bus.seg_flags       <= row.seg.seg_flags;
        seg_bus.header_words    <= row.seg.header_words;
        seg_bus.ip_total_length <= row.seg.ip_total_length;
        @(posedge i_clk);
        while (!seg_bus.ready) @(posedge i_clk);
        advance_connection(row.seg, r_a, r_b, count);
        if (row.typed) begin
            expected_q.push_back(row.want);
        end else begin
            expected_q.push_back(r_a);
            if (count == 2) expected_q.push_back(r_b);
        end
    endtask

    // Stop sending and let every queued result drain
    task automatic settle_block();
        seg_bus.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        if (idx == CFG_INITIAL_SEND_SEQ) iss_reg = value;
        else window_reg = value[15:0];
    endtask

    task automatic reconfigure(logic [31:0] iss, logic [15:0] win);
        settle_block();
        write_register(CFG_INITIAL_SEND_SEQ, iss);
        write_register(CFG_ADVERTISED_WINDOW, 32'(win));
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result beat with the oldest expectation; drive ready
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.send_valid     = res_bus.send_valid;
            got.send_flags     = res_bus.send_flags;
            got.send_seq       = res_bus.send_seq;
            got.send_ack       = res_bus.send_ack;
            got.send_src_port  = res_bus.send_src_port;
            got.send_dst_port  = res_bus.send_dst_port;
            got.deliver_valid  = res_bus.deliver_valid;
            got.deliver_length = res_bus.deliver_length;
            got.conn_state     = res_bus.conn_state;
            got.error_code     = res_bus.error_code;
            got.last_of_run    = res_bus.last_of_run;
            if (expected_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                check_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
                check_field("send_flags", 32'(want.send_flags), 32'(got.send_flags));
                check_field("send_seq", want.send_seq, got.send_seq);
                check_field("send_ack", want.send_ack, got.send_ack);
                check_field("send_src_port", 32'(want.send_src_port),
                            32'(got.send_src_port));
                check_field("send_dst_port", 32'(want.send_dst_port),
                            32'(got.send_dst_port));
                check_field("deliver_valid", 32'(want.deliver_valid),
                            32'(got.deliver_valid));
                check_field("deliver_length", 32'(want.deliver_length),
                            32'(got.deliver_length));
                check_field("conn_state", 32'(want.conn_state), 32'(got.conn_state));
                check_field("error_code", 32'(want.error_code), 32'(got.error_code));
                check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            end
        end
        res_bus.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Hard stop for a hung handshake
    initial begin
        #400000;
        $display("FAIL tcp_server_connection_fsm_unit");
        $finish;
    end

    initial begin
        t_seg        s;
        t_result     syn_ack;
        logic [7:0]  fl;
        logic [16:0] need;
        int          pick;
        int          phase;
        int          i;

        i_rst_n                 = 1'b0;
        seg_bus.valid           = 1'b0;
        seg_bus.checksum_ok     = 1'b0;
        seg_bus.seg_src_port    = '0;
        seg_bus.seg_dst_port    = '0;
        seg_bus.seg_seq         = '0;
        seg_bus.seg_ack         = '0;
        seg_bus.seg_flags       = '0;
        seg_bus.header_words    = '0;
        seg_bus.ip_total_length = '0;
        res_bus.ready           = 1'b0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = CFG_INITIAL_SEND_SEQ;
        cfg_bus.data            = '0;
        idle_on                 = 1'b1;
        mismatches              = 0;
        conn_code               = CODE_LISTEN;
        rcv_next                = '0;
        snd_next                = '0;
        iss_reg                 = '0;
        window_reg              = 16'd14600;

        // SYN-ACK for the opening SYN, with the send sequence at all ones
        syn_ack = segment_beat(SEND_FLAGS_SYN_ACK, 32'hFFFF_FFFF, 32'h0000_0000,
                               make_seg(1'b1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, '0,
                                        FL_SYN, 4'd5, 16'd40));
        syn_ack.conn_state  = CODE_SYN_RCVD;
        syn_ack.error_code  = ERR_NONE;
        syn_ack.last_of_run = 1'b1;

        // Listen: ignore non-SYN, drop bad checksum, answer SYN
        directed_rows[0]  = stim(make_seg(1'b1, '0, '0, '0, '0, FL_ACK, 4'd0, 16'd0),
                                 1'b1, status_beat(CODE_LISTEN, ERR_NONE));
        directed_rows[1]  = stim(make_seg(1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 8'hFF, 4'd15, 16'hFFFF),
                                 1'b1, status_beat(CODE_LISTEN, ERR_BAD_CHECKSUM));
        directed_rows[2]  = stim(make_seg(1'b1, 16'd1234, 16'd80, 32'd1, 32'd2,
                                          8'hFF & ~FL_SYN, 4'd5, 16'd100),
                                 1'b1, status_beat(CODE_LISTEN, ERR_NONE));
        directed_rows[3]  = stim(make_seg(1'b1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, '0,
                                          FL_SYN, 4'd5, 16'd40), 1'b1, syn_ack);
        // Syn received: only ACK advances
        directed_rows[4]  = stim(make_seg(1'b1, 16'd4000, 16'd80, '0, '0, FL_SYN,
                                          4'd5, 16'd40), 1'b0, '0);
        directed_rows[5]  = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd7, 32'd9,
                                          8'hFF & ~FL_ACK, 4'd5, 16'd40), 1'b0, '0);
        directed_rows[6]  = stim(make_seg(1'b0, 16'd4000, 16'd80, '0, 32'd1, FL_ACK,
                                          4'd5, 16'd40),
                                 1'b1, status_beat(CODE_SYN_RCVD, ERR_BAD_CHECKSUM));
        directed_rows[7]  = stim(make_seg(1'b1, 16'd4000, 16'd80, '0, 32'd5, FL_ACK,
                                          4'd5, 16'd40), 1'b0, '0);
        // Established: payload sizes, short and exact headers, errors, ignored bits
        directed_rows[8]  = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd1, 32'h1234_5678,
                                          FL_PSH | FL_ACK, 4'd5, 16'd140), 1'b0, '0);
        directed_rows[9]  = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd2, 32'd3, FL_PSH,
                                          4'd15, 16'd79), 1'b0, '0);
        directed_rows[10] = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd2, 32'd3, FL_PSH,
                                          4'd15, 16'd80), 1'b0, '0);
        directed_rows[11] = stim(make_seg(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, FL_PSH, 4'd0, 16'hFFFF),
                                 1'b0, '0);
        directed_rows[12] = stim(make_seg(1'b1, '0, '0, '0, '0, FL_PSH, 4'd0, 16'd0),
                                 1'b0, '0);
        directed_rows[13] = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd5, 32'd6,
                                          FL_SYN | FL_PSH | FL_FIN, 4'd5, 16'd200),
                                 1'b1, status_beat(CODE_ESTABLISHED, ERR_SYN_IN_EST));
        directed_rows[14] = stim(make_seg(1'b0, 16'd4000, 16'd80, 32'd5, 32'd6,
                                          FL_PSH | FL_FIN, 4'd5, 16'd200),
                                 1'b1, status_beat(CODE_ESTABLISHED, ERR_BAD_CHECKSUM));
        directed_rows[15] = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd5, 32'd6, 8'h00,
                                          4'd5, 16'd200), 1'b0, '0);
        directed_rows[16] = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd5, 32'd6, 8'hE4,
                                          4'd5, 16'd200), 1'b0, '0);
        directed_rows[17] = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd5, 32'd6, FL_PSH,
                                          4'd5, 16'd21), 1'b0, '0);
        // Closing: PSH with FIN, then segments that close wait ignores
        directed_rows[18] = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd9, 32'hDEAD_BEEF,
                                          FL_PSH | FL_FIN | FL_ACK, 4'd5, 16'd60),
                                 1'b0, '0);
        directed_rows[19] = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd9, 32'd10, FL_ACK,
                                          4'd5, 16'd60), 1'b0, '0);
        directed_rows[20] = stim(make_seg(1'b1, 16'd4000, 16'd80, 32'd9, 32'd10, 8'hFF,
                                          4'd5, 16'd60), 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reconfigure(32'hFFFF_FFFF, 16'hFFFF);
        for (i = 0; i < CLOSING_ROW; i++) offer_segment(directed_rows[i]);

        // Random traffic on the open connection, mostly data segments
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       reconfigure(32'h0000_0000, 16'h0000);
                1:       reconfigure(32'hFFFF_FFFF, 16'hFFFF);
                3:       reconfigure(32'h8000_0000, 16'd14600);
                default: reconfigure($urandom, 16'($urandom_range(0, 65535)));
            endcase
            idle_on = (phase != 2);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                s.checksum_ok  = ($urandom_range(0, 15) != 0);
                s.seg_src_port = 16'($urandom_range(0, 65535));
                s.seg_dst_port = 16'($urandom_range(0, 65535));
                s.seg_seq      = $urandom;
                s.seg_ack      = $urandom;
                s.header_words = ($urandom_range(0, 3) == 0) ?
                                 4'($urandom_range(0, 15)) : 4'd5;
                need = 17'(IP_HEADER_BYTES) + 17'({s.header_words, 2'b00});
                pick = $urandom_range(0, 99);
                if (pick < 60) s.ip_total_length = 16'(need + $urandom_range(0, 1460));
                else if (pick < 75) s.ip_total_length = 16'(need - $urandom_range(0, need));
                else s.ip_total_length = 16'($urandom_range(0, 65535));
                fl = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 70) begin
                    fl = (fl & ~(FL_SYN | FL_FIN)) | FL_PSH;
                end else if ((fl & FL_FIN) != 0 && (fl & FL_SYN) == 0 && s.checksum_ok) begin
                    // keep the connection open until the closing rows
                    fl = fl & ~FL_FIN;
                end
                s.seg_flags = fl;
                offer_segment(stim(s, 1'b0, '0));
            end
        end
        idle_on = 1'b1;

        for (i = CLOSING_ROW; i < DIRECTED_ROWS; i++) offer_segment(directed_rows[i]);

        settle_block();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS tcp_server_connection_fsm_unit");
        end else begin
            $display("FAIL tcp_server_connection_fsm_unit");
        end
        $finish;
    end

endmodule
